### design/cjkns_pkg.sv
// ----------------------------------------------------------------------------
// cjkns_pkg
// shared constants, types and helper functions for the cjk density n-gram
// size selector
// ----------------------------------------------------------------------------
package cjkns_pkg;

    // counter and field widths
    localparam int COUNT_BITS = 24;
    localparam int OUT_BITS   = 24;
    localparam int CP_BITS    = 21;
    localparam int SIZE_BITS  = 8;
    localparam int NUM_RANGES = 16;
    localparam int EXT_BITS   = (COUNT_BITS > OUT_BITS) ? COUNT_BITS : OUT_BITS;
    localparam int MUL_BITS   = COUNT_BITS + 4;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [OUT_BITS-1:0]   OUT_MAX   = '1;

    // size selection constants
    localparam logic [SIZE_BITS-1:0] SIZE_RESET = SIZE_BITS'(3);
    localparam logic [SIZE_BITS-1:0] SIZE_FLOOR = SIZE_BITS'(3);
    localparam logic [SIZE_BITS-1:0] SIZE_DENSE = SIZE_BITS'(2);
    localparam logic [MUL_BITS-1:0]  DENSE_CJK_WEIGHT = MUL_BITS'(10);
    localparam logic [MUL_BITS-1:0]  DENSE_ALL_WEIGHT = MUL_BITS'(3);

    // cjk, hangul and kana code point ranges (inclusive)
    localparam logic [CP_BITS-1:0] CJK_LO [NUM_RANGES] = '{
        21'h01100, 21'h03040, 21'h030A0, 21'h031C0, 21'h03200, 21'h03400,
        21'h04E00, 21'h0A960, 21'h0AC00, 21'h0D7B0, 21'h0F900, 21'h20000,
        21'h2EBF0, 21'h2F800, 21'h30000, 21'h31350
    };
    localparam logic [CP_BITS-1:0] CJK_HI [NUM_RANGES] = '{
        21'h011FF, 21'h0309F, 21'h030FF, 21'h031EF, 21'h032FF, 21'h04DBF,
        21'h09FFF, 21'h0A97F, 21'h0D7AF, 21'h0D7FF, 21'h0FAFF, 21'h2EBEF,
        21'h2EE5F, 21'h2FA1F, 21'h3134F, 21'h323AF
    };

    // decoder and counter state carried between bytes
    typedef struct packed {
        logic [CP_BITS-1:0]    partial;
        logic [1:0]            expected;
        logic [1:0]            taken;
        logic [COUNT_BITS-1:0] points;
        logic [COUNT_BITS-1:0] cjks;
    } cjkns_state_t;

    function automatic logic in_cjk(input logic [CP_BITS-1:0] cp);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < NUM_RANGES; i++) begin
            if (cp >= CJK_LO[i] && cp <= CJK_HI[i]) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    // saturating add of a small increment
    function automatic logic [COUNT_BITS-1:0] sat_add(
        input logic [COUNT_BITS-1:0] cnt,
        input logic [2:0]            inc
    );
        logic [COUNT_BITS:0] sum;
        sum = {1'b0, cnt} + (COUNT_BITS+1)'(inc);
        return sum[COUNT_BITS] ? COUNT_MAX : sum[COUNT_BITS-1:0];
    endfunction

    // clamp a counter onto the output field width
    function automatic logic [OUT_BITS-1:0] sat_out(input logic [COUNT_BITS-1:0] cnt);
        logic [EXT_BITS-1:0] ext;
        ext = EXT_BITS'(cnt);
        return (ext > EXT_BITS'(OUT_MAX)) ? OUT_MAX : ext[OUT_BITS-1:0];
    endfunction

endpackage

### design/cjkns_step.sv
// ----------------------------------------------------------------------------
// cjkns_step
// utf-8 decode of one byte, cjk range test and saturating counter update,
// including the truncation flush at end of text
// ----------------------------------------------------------------------------
module cjkns_step (
    input  cjkns_pkg::cjkns_state_t cur_state,
    input  logic [7:0]              text_byte,
    input  logic                    has_byte,
    input  logic                    last_byte,
    output cjkns_pkg::cjkns_state_t nxt_state
);
    import cjkns_pkg::*;

    cjkns_state_t nxt;
    logic [2:0]   point_add;
    logic         cjk_inc;
    logic         is_cont;

    always_comb begin
        nxt       = cur_state;
        point_add = 3'd0;
        cjk_inc   = 1'b0;
        is_cont   = (text_byte[7:6] == 2'b10);

        if (has_byte) begin
            if (cur_state.expected != 2'd0 && is_cont) begin
                // continuation of a pending sequence
                nxt.partial  = {cur_state.partial[CP_BITS-7:0], text_byte[5:0]};
                nxt.expected = cur_state.expected - 2'd1;
                nxt.taken    = cur_state.taken + 2'd1;
                if (nxt.expected == 2'd0) begin
                    cjk_inc     = in_cjk(nxt.partial);
                    nxt.partial = '0;
                    nxt.taken   = 2'd0;
                end
            end else begin
                // fresh byte, after counting any truncated continuations
                point_add    = (cur_state.expected != 2'd0) ?
                               ({1'b0, cur_state.taken} + 3'd1) : 3'd1;
                nxt.partial  = '0;
                nxt.expected = 2'd0;
                nxt.taken    = 2'd0;
                if (text_byte[7:5] == 3'b110) begin
                    nxt.partial  = CP_BITS'(text_byte[4:0]);
                    nxt.expected = 2'd1;
                end else if (text_byte[7:4] == 4'b1110) begin
                    nxt.partial  = CP_BITS'(text_byte[3:0]);
                    nxt.expected = 2'd2;
                end else if (text_byte[7:3] == 5'b11110) begin
                    nxt.partial  = CP_BITS'(text_byte[2:0]);
                    nxt.expected = 2'd3;
                end
            end
        end

        // end of text: a pending sequence counts its taken continuations
        if (last_byte) begin
            if (nxt.expected != 2'd0) begin
                point_add = point_add + {1'b0, nxt.taken};
            end
            nxt.partial  = '0;
            nxt.expected = 2'd0;
            nxt.taken    = 2'd0;
        end

        nxt.points = sat_add(cur_state.points, point_add);
        nxt.cjks   = sat_add(cur_state.cjks, {2'b00, cjk_inc});
    end

    assign nxt_state = nxt;

endmodule

### design/cjk_density_ngram_size_select_core.sv
// ----------------------------------------------------------------------------
// cjk_density_ngram_size_select_core
// streams utf-8 text bytes, counts code points and cjk code points, and on
// the last byte picks the n-gram size from the cjk density
// ----------------------------------------------------------------------------
// flow: a byte is registered at the input and decoded and counted from there;
//   a last byte leaves only when the result register is free, loading m_*
// throughput: one byte per cycle unless a last byte waits for a free result
//   register, set by the combinational decode, range test and counter update
//   between the input register and the state registers
// reset: synchronous, active-low aresetn; clears counters, decoder state and
//   valid flags, and sets default_size to 3
// ----------------------------------------------------------------------------
module cjk_density_ngram_size_select_core (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // configuration write channel (default_size)
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [cjkns_pkg::SIZE_BITS-1:0]       cfg_data,
    // byte request channel
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [7:0]                            s_text_byte,
    input  logic                                  s_has_byte,
    input  logic                                  s_last_byte,
    // result channel
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [cjkns_pkg::SIZE_BITS-1:0]       m_chosen_size,
    output logic                                  m_cjk_dense,
    output logic [cjkns_pkg::OUT_BITS-1:0]        m_code_point_total,
    output logic [cjkns_pkg::OUT_BITS-1:0]        m_cjk_point_total
);
    import cjkns_pkg::*;

    // configuration register, always writable
    logic [SIZE_BITS-1:0] default_size_reg;

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_has_reg;
    logic       in_last_reg;

    // running decoder and counter state
    cjkns_state_t state_reg;
    cjkns_state_t state_next;

    // result register
    logic                 out_valid_reg;
    logic [SIZE_BITS-1:0] out_size_reg;
    logic                 out_dense_reg;
    logic [OUT_BITS-1:0]  out_points_reg;
    logic [OUT_BITS-1:0]  out_cjks_reg;

    // result formation
    logic                 out_free;
    logic                 step_fire;
    logic                 res_fire;
    logic [MUL_BITS-1:0]  cjk_weighted;
    logic [MUL_BITS-1:0]  all_weighted;
    logic                 res_dense;
    logic [SIZE_BITS-1:0] res_size;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            default_size_reg <= SIZE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            default_size_reg <= cfg_data;
        end
    end

    // a non-last byte never waits on the result side; the last one needs a
    // free result register
    assign out_free  = !out_valid_reg || m_ready;
    assign step_fire = in_valid_reg && (!in_last_reg || out_free);
    assign res_fire  = step_fire && in_last_reg;
    assign s_ready   = !in_valid_reg || step_fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_text_byte;
            in_has_reg  <= s_has_byte;
            in_last_reg <= s_last_byte;
        end
    end

    cjkns_step u_step (
        .cur_state (state_reg),
        .text_byte (in_byte_reg),
        .has_byte  (in_has_reg),
        .last_byte (in_last_reg),
        .nxt_state (state_next)
    );

    // state clears after each text so the next one starts fresh
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (res_fire) begin
            state_reg <= '0;
        end else if (step_fire) begin
            state_reg <= state_next;
        end
    end

    // density test: 10 * cjk > 3 * all, only when the text was not empty
    assign cjk_weighted = MUL_BITS'(state_next.cjks) * DENSE_CJK_WEIGHT;
    assign all_weighted = MUL_BITS'(state_next.points) * DENSE_ALL_WEIGHT;

    always_comb begin
        res_dense = 1'b0;
        res_size  = default_size_reg;
        if (state_next.points != '0) begin
            res_dense = (cjk_weighted > all_weighted);
            if (res_dense) begin
                res_size = SIZE_DENSE;
            end else if (default_size_reg < SIZE_FLOOR) begin
                res_size = SIZE_FLOOR;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_fire) begin
            out_size_reg   <= res_size;
            out_dense_reg  <= res_dense;
            out_points_reg <= sat_out(state_next.points);
            out_cjks_reg   <= sat_out(state_next.cjks);
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_chosen_size      = out_size_reg;
    assign m_cjk_dense        = out_dense_reg;
    assign m_code_point_total = out_points_reg;
    assign m_cjk_point_total  = out_cjks_reg;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------

    // every cjk point was also counted as a point
    a_cjk_le_points: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.cjks <= state_reg.points)
        else $error("cjk count above total count");

    // no partial sequence data without a pending sequence
    a_idle_decoder_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.expected == 2'd0) |-> (state_reg.partial == '0 && state_reg.taken == 2'd0))
        else $error("stale decoder state with no sequence pending");

    // a delivered text leaves the counters clear
    a_clear_after_result: assert property (@(posedge aclk) disable iff (!aresetn)
        res_fire |=> (state_reg.points == '0 && state_reg.cjks == '0
                      && state_reg.expected == 2'd0))
        else $error("state not cleared after result");

    // dense texts always select the short size
    a_dense_size: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_dense_reg) |-> (out_size_reg == SIZE_DENSE))
        else $error("dense result with wrong size");

endmodule
